// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication: whenever ante holds, cons holds in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/epl_pkg.sv =====
// Package of the epipolar line angle block: widths, codes, arctangent table, types.
// No dependencies.
package epl_pkg;

  localparam int AngleIterationsDef = 16;
  localparam int TableLen = 24;
  localparam int DW = 34;          // dx, dy width (signed Q.4)
  localparam int PW = 66;          // product width
  localparam int SW = 67;          // sum of two products
  localparam int MW = 64;          // magnitude width
  localparam int NormTop = 39;
  localparam int XW = 42;          // CORDIC x, y width
  localparam int ZW = 34;          // CORDIC angle accumulator width

  localparam logic signed [ZW-1:0] Deg90Q24 = ZW'(90) <<< 24;
  localparam logic [15:0] Deg90Q88 = 16'd23040;
  localparam logic [15:0] Deg180Q88 = 16'd46080;

  localparam logic [31:0] AtanQ24 [TableLen] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
    32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
    32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229, 32'd115
  };

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_EPI_X = 3'd1,
    REG_EPI_Y = 3'd2,
    REG_F00   = 3'd3,
    REG_F01   = 3'd4,
    REG_F10   = 3'd5,
    REG_F11   = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_ATAN   = 2'd0,
    KIND_ZERO   = 2'd1,
    KIND_NINETY = 2'd2,
    KIND_DEGEN  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  flip;   // numerator and denominator have opposite signs
  } tag_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    tag_t                 tag;
  } rot_t;

endpackage

// ===== rtl/epipolar_line_angle.sv =====
// Top level of the epipolar line angle block: offsets, products, normalize, output.
// Depends on epl_pkg and epl_cordic.

// Takes one edge point per beat and returns the line angle in degrees (Q8.8, 0 up
// to below 180) one beat per point, in order. Its stages are the offset, product,
// sum, leading-one search and normalize stages, one stage per CORDIC iteration,
// and the output register. One point enters every cycle; the whole pipeline
// advances whenever the output register is empty or being taken. The user must
// write configuration only while no points are in flight; it is not enforced.
module epipolar_line_angle #(
  parameter int ANGLE_ITERATIONS = epl_pkg::AngleIterationsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // edge_x [15:0], edge_y [31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // angle_deg [15:0]
  output logic        m_axis_tuser    // degenerate [0]
);

  localparam int DW = epl_pkg::DW;
  localparam int PW = epl_pkg::PW;
  localparam int SW = epl_pkg::SW;
  localparam int MW = epl_pkg::MW;
  localparam int XW = epl_pkg::XW;
  localparam int ZW = epl_pkg::ZW;

  // Configuration registers.
  logic               mode_q;
  logic signed [31:0] epi_x_q, epi_y_q, f00_q, f01_q, f10_q, f11_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      epi_x_q <= '0;
      epi_y_q <= '0;
      f00_q   <= '0;
      f01_q   <= '0;
      f10_q   <= '0;
      f11_q   <= '0;
    end else if (cfg_we_i) begin
      case (epl_pkg::cfg_reg_e'(cfg_addr_i))
        epl_pkg::REG_MODE:  mode_q  <= cfg_wdata_i[0];
        epl_pkg::REG_EPI_X: epi_x_q <= cfg_wdata_i;
        epl_pkg::REG_EPI_Y: epi_y_q <= cfg_wdata_i;
        epl_pkg::REG_F00:   f00_q   <= cfg_wdata_i;
        epl_pkg::REG_F01:   f01_q   <= cfg_wdata_i;
        epl_pkg::REG_F10:   f10_q   <= cfg_wdata_i;
        epl_pkg::REG_F11:   f11_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: offsets from the epipole.
  logic                 v1_q;
  logic signed [DW-1:0] dx1_q, dy1_q, dx1_d, dy1_d;

  assign dx1_d = $signed({14'd0, s_axis_tdata[15:0], 4'd0}) - DW'(epi_x_q);
  assign dy1_d = $signed({14'd0, s_axis_tdata[31:16], 4'd0}) - DW'(epi_y_q);

  // Stage 2: the four matrix products.
  logic                 v2_q;
  logic signed [DW-1:0] dx2_q, dy2_q;
  logic signed [PW-1:0] p00_q, p01_q, p10_q, p11_q;

  // Stage 3: numerator and denominator as sign and magnitude.
  logic                 v3_q;
  logic [MW-1:0]        num3_q, den3_q, num3_d, den3_d;
  epl_pkg::tag_t        tag3_q, tag3_d;
  logic signed [SW-1:0] num_s, den_s;
  logic                 num_neg, den_neg;

  always_comb begin
    if (mode_q) begin
      num_s = -(SW'(p00_q) + SW'(p01_q));
      den_s = SW'(p10_q) + SW'(p11_q);
    end else begin
      num_s = SW'(dy2_q);
      den_s = SW'(dx2_q);
    end
    num_neg = num_s < 0;
    den_neg = den_s < 0;
    num3_d  = num_neg ? MW'(-num_s) : MW'(num_s);
    den3_d  = den_neg ? MW'(-den_s) : MW'(den_s);
    tag3_d.flip = num_neg ^ den_neg;
    if (num3_d == '0 && den3_d == '0) begin
      tag3_d.kind = epl_pkg::KIND_DEGEN;
    end else if (num3_d == '0) begin
      tag3_d.kind = epl_pkg::KIND_ZERO;
    end else if (den3_d == '0) begin
      tag3_d.kind = epl_pkg::KIND_NINETY;
    end else begin
      tag3_d.kind = epl_pkg::KIND_ATAN;
    end
  end

  // Stage 4: leading one of the larger magnitude.
  logic          v4_q;
  logic [MW-1:0] num4_q, den4_q, both;
  logic [5:0]    msb4_q, msb4_d;
  epl_pkg::tag_t tag4_q;

  assign both = num3_q | den3_q;
  always_comb begin
    msb4_d = '0;
    for (int b = 0; b < MW; b++) begin
      if (both[b]) msb4_d = 6'(b);
    end
  end

  // Stage 5: scale both so the larger lies in [2^38, 2^39).
  logic          v5_q;
  epl_pkg::rot_t rot5_q, rot5_d;
  logic [MW-1:0] num_sh, den_sh;

  always_comb begin
    if (msb4_q >= 6'(epl_pkg::NormTop - 1)) begin
      num_sh = num4_q >> (msb4_q - 6'(epl_pkg::NormTop - 1));
      den_sh = den4_q >> (msb4_q - 6'(epl_pkg::NormTop - 1));
    end else begin
      num_sh = num4_q << (6'(epl_pkg::NormTop - 1) - msb4_q);
      den_sh = den4_q << (6'(epl_pkg::NormTop - 1) - msb4_q);
    end
    rot5_d.x   = $signed(XW'(den_sh[epl_pkg::NormTop-1:0]));
    rot5_d.y   = $signed(XW'(num_sh[epl_pkg::NormTop-1:0]));
    rot5_d.z   = '0;
    rot5_d.tag = tag4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q  <= dx1_d;
      dy1_q  <= dy1_d;
      dx2_q  <= dx1_q;
      dy2_q  <= dy1_q;
      p00_q  <= PW'(f00_q) * PW'(dx1_q);
      p01_q  <= PW'(f01_q) * PW'(dy1_q);
      p10_q  <= PW'(f10_q) * PW'(dx1_q);
      p11_q  <= PW'(f11_q) * PW'(dy1_q);
      num3_q <= num3_d;
      den3_q <= den3_d;
      tag3_q <= tag3_d;
      num4_q <= num3_q;
      den4_q <= den3_q;
      msb4_q <= msb4_d;
      tag4_q <= tag3_q;
      rot5_q <= rot5_d;
    end
  end

  logic          vc;
  epl_pkg::rot_t rotc;

  epl_cordic #(
    .ITER (ANGLE_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .rot_i   (rot5_q),
    .valid_o (vc),
    .rot_o   (rotc)
  );

  // Output stage: clamp, round to Q8.8, fold into [0, 180).
  logic signed [ZW-1:0] zc;
  logic [ZW-1:0]        rnd;
  logic [15:0]          a16, angle_d, angle_q;
  logic                 degen_d, degen_q, out_vld_q;

  always_comb begin
    if (rotc.z < 0) begin
      zc = '0;
    end else if (rotc.z > epl_pkg::Deg90Q24) begin
      zc = epl_pkg::Deg90Q24;
    end else begin
      zc = rotc.z;
    end
    rnd     = ZW'(zc) + ZW'(32768);
    a16     = rnd[31:16];
    degen_d = 1'b0;
    case (rotc.tag.kind)
      epl_pkg::KIND_DEGEN: begin
        angle_d = '0;
        degen_d = 1'b1;
      end
      epl_pkg::KIND_ZERO:   angle_d = '0;
      epl_pkg::KIND_NINETY: angle_d = epl_pkg::Deg90Q88;
      default: begin
        angle_d = rotc.tag.flip ? epl_pkg::Deg180Q88 - a16 : a16;
        if (angle_d >= epl_pkg::Deg180Q88) angle_d = angle_d - epl_pkg::Deg180Q88;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_q <= angle_d;
      degen_q <= degen_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = angle_q;
  assign m_axis_tuser  = degen_q;

endmodule

// ===== rtl/epl_cordic.sv =====
// Pipelined CORDIC vectoring unit, one register stage per iteration.
// Depends on epl_pkg.
module epl_cordic #(
  parameter int ITER = epl_pkg::AngleIterationsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  epl_pkg::rot_t  rot_i,
  output logic           valid_o,
  output epl_pkg::rot_t  rot_o
);

  logic          vld_q [ITER+1];
  epl_pkg::rot_t st_q  [ITER+1];

  assign vld_q[0] = valid_i;
  assign st_q[0]  = rot_i;

  for (genvar i = 0; i < ITER; i++) begin : g_stage
    epl_pkg::rot_t nxt_d;

    always_comb begin
      nxt_d = st_q[i];
      if (st_q[i].y > 0) begin
        nxt_d.x = st_q[i].x + (st_q[i].y >>> i);
        nxt_d.y = st_q[i].y - (st_q[i].x >>> i);
        nxt_d.z = st_q[i].z + epl_pkg::ZW'(epl_pkg::AtanQ24[i]);
      end else begin
        nxt_d.x = st_q[i].x - (st_q[i].y >>> i);
        nxt_d.y = st_q[i].y + (st_q[i].x >>> i);
        nxt_d.z = st_q[i].z - epl_pkg::ZW'(epl_pkg::AtanQ24[i]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i+1] <= nxt_d;
      end
    end
  end

  assign valid_o = vld_q[ITER];
  assign rot_o   = st_q[ITER];

endmodule

// ===== rtl/epl_checker.sv =====
// Port-level checker for the epipolar line angle block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module epl_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled output beat changed")
  `ASSERT_IMPL(a_degen_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 16'd0, "degenerate beat with nonzero angle")
  `ASSERT_IMPL(a_angle_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata < 16'd46080, "angle not below 180 degrees")

endmodule

bind epipolar_line_angle epl_props u_epl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
